// ===== rtl/dithered_span_fill_unit_defines.svh =====
// Assertion macros shared by the dithered span fill RTL.
`ifndef DITHERED_SPAN_FILL_UNIT_DEFINES_SVH
`define DITHERED_SPAN_FILL_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dsf_pkg.sv =====
// Package with types, constants and the dither pattern function of the span fill unit.
`default_nettype none
package dsf_pkg;

  localparam int DefScreenWidth  = 144;
  localparam int DefScreenHeight = 168;
  localparam int DefRowBytes     = 20;

  localparam int CoordW   = 16;
  localparam int ColW     = 8;
  localparam int ByteIdxW = 5;
  localparam int RowIdxW  = 10;
  localparam int AddrW    = 12;
  localparam int DataW    = 8;
  localparam int InTdataW  = 48;
  localparam int OutTdataW = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } dsf_state_e;

  typedef struct packed {
    logic            drop;
    logic [ColW-1:0] lo;
    logic [ColW-1:0] hi;
  } dsf_clip_t;

  localparam logic [7:0] BAYER [8][8] = '{
    '{8'd0,   8'd128, 8'd32,  8'd160, 8'd8,   8'd136, 8'd40,  8'd168},
    '{8'd192, 8'd64,  8'd224, 8'd96,  8'd200, 8'd72,  8'd232, 8'd104},
    '{8'd48,  8'd176, 8'd16,  8'd144, 8'd56,  8'd184, 8'd24,  8'd152},
    '{8'd240, 8'd112, 8'd208, 8'd80,  8'd248, 8'd120, 8'd216, 8'd88},
    '{8'd12,  8'd140, 8'd44,  8'd172, 8'd4,   8'd132, 8'd36,  8'd164},
    '{8'd204, 8'd76,  8'd236, 8'd108, 8'd196, 8'd68,  8'd228, 8'd100},
    '{8'd60,  8'd188, 8'd28,  8'd156, 8'd52,  8'd180, 8'd20,  8'd148},
    '{8'd252, 8'd124, 8'd220, 8'd92,  8'd244, 8'd116, 8'd212, 8'd84}
  };

  // Dither column c of the Bayer row lands on bit 7 - c.
  function automatic logic [DataW-1:0] row_pattern(input logic [2:0] r,
                                                   input logic [DataW-1:0] gray);
    logic [DataW-1:0] p;
    p = '0;
    for (int c = 0; c < 8; c++) begin
      p[7-c] = (gray > BAYER[r][c]);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dsf_span_clip.sv =====
// Span rejection and clamping of one span to the visible screen area.
`default_nettype none
module dsf_span_clip
  import dsf_pkg::*;
#(
  parameter int DISP_WIDTH  = DefScreenWidth,
  parameter int DISP_HEIGHT = DefScreenHeight
) (
  input  logic signed [CoordW-1:0] row_i,
  input  logic signed [CoordW-1:0] x_start_i,
  input  logic signed [CoordW-1:0] x_end_i,
  output dsf_clip_t                clip_o
);

  logic signed [CoordW:0] w_max;
  logic signed [CoordW:0] h_lim;
  logic signed [CoordW:0] row_ext;
  logic signed [CoordW:0] xs_ext;
  logic signed [CoordW:0] xe_ext;
  logic signed [CoordW:0] lo_ext;
  logic signed [CoordW:0] lo_c;
  logic signed [CoordW:0] hi_c;

  always_comb begin
    w_max   = (CoordW+1)'(DISP_WIDTH - 1);
    h_lim   = (CoordW+1)'(DISP_HEIGHT);
    row_ext = $signed({row_i[CoordW-1], row_i});
    xs_ext  = $signed({x_start_i[CoordW-1], x_start_i});
    xe_ext  = $signed({x_end_i[CoordW-1], x_end_i});
    lo_ext  = xs_ext - (CoordW+1)'(1);
    lo_c    = (lo_ext < 0) ? '0 : lo_ext;
    hi_c    = (xe_ext > w_max) ? w_max : xe_ext;
    clip_o.drop = (xe_ext < xs_ext) || (row_ext < 0) || (row_ext >= h_lim) ||
                  (lo_c > hi_c);
    clip_o.lo   = lo_c[ColW-1:0];
    clip_o.hi   = hi_c[ColW-1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/dithered_span_fill_unit.sv =====
// Top level of the dithered span fill unit for a 1-bit packed framebuffer.
// A span is accepted in the idle state, checked and clamped in the setup state, then emits one
// masked byte write per cycle, unless the output stalls, from a shared address incrementer.
// A rejected span goes from setup back to idle; the next span is accepted once the last write is loaded.
// Output stalls hold the sequencer; the output register lets the next span be accepted.
// Reset is asynchronous and active low: gray level returns to zero, the unit goes idle.
`default_nettype none
`include "dithered_span_fill_unit_defines.svh"
module dithered_span_fill_unit
  import dsf_pkg::*;
#(
  parameter int DISP_WIDTH  = DefScreenWidth,
  parameter int DISP_HEIGHT = DefScreenHeight,
  parameter int ROW_BYTES   = DefRowBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [DataW-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // Fields from bit 0: row[15:0], x_start[31:16], x_end[47:32].
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // Fields from bit 0: byte_address[11:0], write_data[19:12], write_mask[27:20], zero fill.
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // Field: last_write.
  output logic                 m_axis_tlast_o
);

  dsf_state_e state_q, state_d;
  logic [DataW-1:0]     gray_q;
  logic [CoordW-1:0]    row_q, xs_q, xe_q;
  logic [ColW-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [ByteIdxW-1:0]  b_q, b_d, lb_q, lb_d;
  logic [AddrW-1:0]     addr_q, addr_d;
  logic [DataW-1:0]     pat_q, pat_d;
  logic                 ov_q, ov_d;
  logic [AddrW-1:0]     oaddr_q, oaddr_d;
  logic [DataW-1:0]     odata_q, odata_d;
  logic [DataW-1:0]     omask_q, omask_d;
  logic                 olast_q, olast_d;
  logic                 accept;
  logic                 load;
  logic                 is_last;
  logic [DataW-1:0]     mask;
  logic [AddrW-1:0]     base;
  dsf_clip_t            clip;

  dsf_span_clip #(
    .DISP_WIDTH (DISP_WIDTH),
    .DISP_HEIGHT(DISP_HEIGHT)
  ) u_clip (
    .row_i    (row_q),
    .x_start_i(xs_q),
    .x_end_i  (xe_q),
    .clip_o   (clip)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign load            = (state_q == ST_EMIT) && (!ov_q || m_axis_tready_i);
  assign is_last         = (b_q == lb_q);
  assign base            = AddrW'(32'(row_q[RowIdxW-1:0]) * ROW_BYTES);

  always_comb begin
    mask = 8'hFF;
    if (b_q == lo_q[ColW-1:3]) begin
      mask = mask & (8'hFF << lo_q[2:0]);
    end
    if (is_last) begin
      mask = mask & (8'hFF >> (3'd7 - hi_q[2:0]));
    end
  end

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    b_d     = b_q;
    lb_d    = lb_q;
    addr_d  = addr_q;
    pat_d   = pat_q;
    ov_d    = ov_q && !m_axis_tready_i;
    oaddr_d = oaddr_q;
    odata_d = odata_q;
    omask_d = omask_q;
    olast_d = olast_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        lo_d   = clip.lo;
        hi_d   = clip.hi;
        b_d    = clip.lo[ColW-1:3];
        lb_d   = clip.hi[ColW-1:3];
        addr_d = base + AddrW'(clip.lo[ColW-1:3]);
        pat_d  = row_pattern(row_q[2:0], gray_q);
        state_d = clip.drop ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          ov_d    = 1'b1;
          oaddr_d = addr_q;
          odata_d = pat_q;
          omask_d = mask;
          olast_d = is_last;
          b_d     = b_q + ByteIdxW'(1);
          addr_d  = addr_q + AddrW'(1);
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gray_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        gray_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= s_axis_tdata_i[15:0];
      xs_q  <= s_axis_tdata_i[31:16];
      xe_q  <= s_axis_tdata_i[47:32];
    end
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    b_q     <= b_d;
    lb_q    <= lb_d;
    addr_q  <= addr_d;
    pat_q   <= pat_d;
    oaddr_q <= oaddr_d;
    odata_q <= odata_d;
    omask_q <= omask_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {4'b0000, omask_q, odata_q, oaddr_q};
  assign m_axis_tlast_o  = olast_q;

  `DSF_ASSERT_NOW(a_byte_in_span, state_q == ST_EMIT, b_q <= lb_q, "byte index beyond span")
  `DSF_ASSERT_NEXT(a_last_ends_span, load && is_last, state_q == ST_IDLE, "span did not end")
  `DSF_ASSERT_NOW(a_mask_nonzero, m_axis_tvalid_o, omask_q != 8'h00, "empty write mask")

endmodule
`default_nettype wire

// ===== sim/dithered_span_fill_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the dithered span fill unit, with its own write predictor.
module dithered_span_fill_unit_tb;
  import dsf_pkg::DataW;
  import dsf_pkg::InTdataW;
  import dsf_pkg::OutTdataW;

  localparam int ScrW     = 144;
  localparam int ScrH     = 168;
  localparam int RowBytes = 20;
  localparam int HoldCycles  = 80;
  localparam int SettleCycles = 8;
  localparam int QuietLimit  = 1000;
  localparam int PhaseSpans  = 50;

  typedef enum int {
    SPAN_WELL,
    SPAN_NOISE,
    SPAN_EDGE
  } span_kind_e;

  typedef struct {
    logic [7:0]         gray;
    logic signed [15:0] row;
    logic signed [15:0] xs;
    logic signed [15:0] xe;
    int                 n;
    int                 addr0;
    logic [7:0]         data;
    logic [7:0]         mfirst;
    logic [7:0]         mlast;
  } span_case_t;

  typedef struct {
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  mask;
    logic        last;
  } fill_write_t;

  // Ordered-dither thresholds, indexed by {row mod 8, dither column}.
  localparam logic [7:0] THRESH [64] = '{
    0,   128, 32,  160, 8,   136, 40,  168,
    192, 64,  224, 96,  200, 72,  232, 104,
    48,  176, 16,  144, 56,  184, 24,  152,
    240, 112, 208, 80,  248, 120, 216, 88,
    12,  140, 44,  172, 4,   132, 36,  164,
    204, 76,  236, 108, 196, 68,  228, 100,
    60,  188, 28,  156, 52,  180, 20,  148,
    252, 124, 220, 92,  244, 116, 212, 84
  };

  // A count of -1 leaves the row to the predictor.
  span_case_t dir_tab [23] = '{
    '{0,   0,      1,      143,    18, 0,    8'h00, 8'hFF, 8'hFF},
    '{0,   167,    -32768, 32767,  18, 3340, 8'h00, 8'hFF, 8'hFF},
    '{0,   5,      10,     9,      0,  0,    8'h00, 8'h00, 8'h00},
    '{0,   -1,     0,      50,     0,  0,    8'h00, 8'h00, 8'h00},
    '{0,   -32768, 0,      5,      0,  0,    8'h00, 8'h00, 8'h00},
    '{0,   168,    0,      5,      0,  0,    8'h00, 8'h00, 8'h00},
    '{0,   32767,  0,      5,      0,  0,    8'h00, 8'h00, 8'h00},
    '{0,   3,      200,    300,    0,  0,    8'h00, 8'h00, 8'h00},
    '{0,   3,      -50,    -1,     0,  0,    8'h00, 8'h00, 8'h00},
    '{0,   0,      -32768, -32768, 0,  0,    8'h00, 8'h00, 8'h00},
    '{0,   0,      32767,  32767,  0,  0,    8'h00, 8'h00, 8'h00},
    '{0,   4,      0,      0,      1,  80,   8'h00, 8'h01, 8'h01},
    '{255, 2,      1,      1,      1,  40,   8'hFF, 8'h03, 8'h03},
    '{255, 1,      144,    144,    1,  37,   8'hFF, 8'h80, 8'h80},
    '{255, 1,      145,    150,    0,  0,    8'h00, 8'h00, 8'h00},
    '{255, 166,    -10,    143,    18, 3320, 8'hFF, 8'hFF, 8'hFF},
    '{255, 9,      3,      12,     -1, 0,    8'h00, 8'h00, 8'h00},
    '{1,   0,      0,      7,      -1, 0,    8'h00, 8'h00, 8'h00},
    '{1,   8,      9,      16,     -1, 0,    8'h00, 8'h00, 8'h00},
    '{128, 3,      17,     120,    -1, 0,    8'h00, 8'h00, 8'h00},
    '{77,  6,      30,     31,     -1, 0,    8'h00, 8'h00, 8'h00},
    '{200, 7,      63,     64,     -1, 0,    8'h00, 8'h00, 8'h00},
    '{254, 10,     -5,     8,      -1, 0,    8'h00, 8'h00, 8'h00}
  };

  logic                 clk_i;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [DataW-1:0]     cfg_wdata = '0;
  logic                 s_valid   = 1'b0;
  logic [InTdataW-1:0]  s_data    = '0;
  logic                 m_ready   = 1'b0;
  logic                 s_ready;
  logic                 m_valid;
  logic [OutTdataW-1:0] m_data;
  logic                 m_last;

  fill_write_t pending_writes [$];
  logic [7:0]  gray_now   = 8'd0;
  bit          calm       = 1'b0;
  bit          hold_req   = 1'b0;
  int          err_cnt    = 0;
  int          spans_sent = 0;
  int          spans_empty = 0;
  int          writes_seen = 0;
  int          gray_writes = 0;
  int          quiet      = 0;

  dithered_span_fill_unit #(
    .DISP_WIDTH (ScrW),
    .DISP_HEIGHT(ScrH),
    .ROW_BYTES  (RowBytes)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] row_dither(input logic [2:0] r, input logic [7:0] gray);
    logic [7:0] p;
    p = '0;
    for (int c = 0; c < 8; c++) begin
      if (gray > THRESH[{r, 3'(c)}]) p[7-c] = 1'b1;
    end
    return p;
  endfunction

  task automatic predict_span(input logic signed [15:0] row, input logic signed [15:0] xs,
                              input logic signed [15:0] xe);
    int          lo;
    int          hi;
    fill_write_t w;
    if (xe < xs || row < 0 || row >= ScrH) begin
      spans_empty++;
      return;
    end
    lo = int'(xs) - 1;
    hi = int'(xe);
    if (lo < 0) lo = 0;
    if (hi > ScrW - 1) hi = ScrW - 1;
    if (lo > hi) begin
      spans_empty++;
      return;
    end
    for (int b = lo / 8; b <= hi / 8; b++) begin
      w.addr = 12'(int'(row) * RowBytes + b);
      w.data = row_dither(row[2:0], gray_now);
      w.mask = 8'hFF;
      if (b == lo / 8) w.mask &= 8'hFF << (lo % 8);
      if (b == hi / 8) w.mask &= 8'hFF >> (7 - hi % 8);
      w.last = (b == hi / 8);
      pending_writes.push_back(w);
    end
  endtask

  task automatic push_typed(input span_case_t sc);
    fill_write_t w;
    if (sc.n == 0) spans_empty++;
    for (int k = 0; k < sc.n; k++) begin
      w.addr = 12'(sc.addr0 + k);
      w.data = sc.data;
      w.mask = (k == 0) ? sc.mfirst : (k == sc.n - 1) ? sc.mlast : 8'hFF;
      w.last = (k == sc.n - 1);
      pending_writes.push_back(w);
    end
  endtask

  task automatic send_span(input span_case_t sc);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= {sc.xe, sc.xs, sc.row};
    do @(posedge clk_i); while (!s_ready);
    if (sc.n < 0) predict_span(sc.row, sc.xs, sc.xe);
    else push_typed(sc);
    spans_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_gray(input logic [7:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    gray_now = v;
    gray_writes++;
  endtask

  function automatic span_case_t random_span();
    span_case_t   sc;
    span_kind_e   kind;
    int           pick;
    int           len;
    logic [15:0]  edges [8];
    edges = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'd143, 16'd144, 16'd145, 16'h7FFF};
    sc   = '{default: 0};
    sc.n = -1;
    pick = $urandom_range(0, 99);
    kind = (pick < 70) ? SPAN_WELL : (pick < 85) ? SPAN_NOISE : SPAN_EDGE;
    case (kind)
      SPAN_WELL: begin
        sc.row = 16'($urandom_range(0, ScrH - 1));
        sc.xs  = 16'(int'($urandom_range(0, 159)) - 8);
        len    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 170) : $urandom_range(0, 24);
        sc.xe  = 16'(int'(sc.xs) + len);
      end
      SPAN_NOISE: begin
        sc.row = 16'($urandom());
        sc.xs  = 16'($urandom());
        sc.xe  = 16'($urandom());
      end
      default: begin
        pick   = $urandom_range(0, 3);
        sc.row = (pick == 0) ? -16'sd1 : (pick == 1) ? 16'sd0 : (pick == 2) ? 16'sd167 : 16'sd168;
        sc.xs  = edges[$urandom_range(0, 7)];
        sc.xe  = edges[$urandom_range(0, 7)];
      end
    endcase
    return sc;
  endfunction

  initial begin : stimulus
    logic [7:0] phase_gray [4];
    repeat (6) @(negedge clk_i);
    rst_n <= 1'b1;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].gray != gray_now) set_gray(dir_tab[i].gray);
      send_span(dir_tab[i]);
    end
    phase_gray = '{8'($urandom_range(1, 254)), 8'd255, 8'($urandom_range(0, 255)), 8'd0};
    for (int ph = 0; ph < 4; ph++) begin
      set_gray(phase_gray[ph]);
      if (ph == 3) calm = 1'b1;
      for (int k = 0; k < PhaseSpans; k++) begin
        if (ph == 0 && k == 2) hold_req = 1'b1;
        send_span(random_span());
      end
    end
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d spans (%0d producing no writes), checked %0d byte writes.",
             spans_sent, spans_empty, writes_seen);
    $display("Gray level was written %0d times, including both extremes.", gray_writes);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : write_sink
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_ready <= 1'b0;
        for (int c = 1; c < HoldCycles; c++) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    fill_write_t w;
    if (rst_n && m_valid && m_ready) begin
      writes_seen++;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: byte_address %0d, write_mask %h", m_data[11:0], m_data[27:20]);
        err_cnt++;
      end else begin
        w = pending_writes.pop_front();
        if (m_data[11:0] !== w.addr) begin
          $error("byte_address: expected %0d, got %0d", w.addr, m_data[11:0]);
          err_cnt++;
        end
        if (m_data[19:12] !== w.data) begin
          $error("write_data: expected %h, got %h", w.data, m_data[19:12]);
          err_cnt++;
        end
        if (m_data[27:20] !== w.mask) begin
          $error("write_mask: expected %h, got %h", w.mask, m_data[27:20]);
          err_cnt++;
        end
        if (m_last !== w.last) begin
          $error("last_write: expected %0b, got %0b", w.last, m_last);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
